[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of the project.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hw/rtl/ptw_pkg.sv]
// Constants, codes and helpers of the page table walker.
// No dependencies; used by the top level and its checker.
`timescale 1ns / 1ps

package ptw_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int LEVELS      = 4;

    localparam int IDX_W    = 9;
    localparam int ENTRIES  = 1 << IDX_W;
    localparam int OFF_W    = 12;
    localparam int VA_W     = 48;
    localparam int PAGE_W   = 40;
    localparam int PA_W     = 52;
    localparam int ENTRY_W  = PAGE_W + 1;
    localparam int CNT_W    = 11;
    localparam int SLOT_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ADDR_W   = SLOT_W + IDX_W;
    localparam int DEPTH    = TABLE_SLOTS * ENTRIES;
    localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int VA_EXT_W = (OFF_W + IDX_W * LEVELS > VA_W) ? OFF_W + IDX_W * LEVELS : VA_W;

    localparam int S_TDATA_W  = 96;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int REG_SLOT_LIMIT_ADDR = 0;
    localparam int SLOT_LIMIT_RESET    = 16;

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_MAP       = 2'd1,
        OP_UNMAP     = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_MISMATCH  = 2'd3
    } status_t;

    // Table index used at walk depth lvl (depth 0 is the root); fields above
    // the top of the virtual address read as zero.
    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [LVL_W-1:0] lvl);
        logic [VA_EXT_W-1:0] ext;
        ext = VA_EXT_W'(va);
        return ext[OFF_W + IDX_W * (LEVELS - 1 - int'(lvl)) +: IDX_W];
    endfunction

endpackage

[hw/rtl/page_table_walker_top.sv]
// Page table walker: sequencer around a single table store memory.
// Depends on ptw_pkg.
//
//  channel | direction | handshake          | contents
//  s_      | in        | s_tvalid/s_tready  | tuser opcode; tdata va, page, overwrite
//  m_      | out       | m_tvalid/m_tready  | tdata physical address, status
//  apb     | in        | psel/penable       | table_slot_limit at address 0
//
// The root read is issued as a word is taken; then each level reads, checks
// and possibly writes back one entry on the memory's single read port. The
// result sits in an output register, so the next word is taken while it
// waits. After reset the store is cleared one entry a cycle, all
// TABLE_SLOTS * 512 entries, during which s_tready stays low.
`timescale 1ns / 1ps

module page_table_walker_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // virtual_address[47:0], physical_page[87:48], overwrite[88], zero pad
    input  logic [ptw_pkg::S_TDATA_W-1:0]    s_tdata,
    // opcode[1:0]
    input  logic [ptw_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // physical_address[51:0], status[53:52], zero pad
    output logic [ptw_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ptw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ptw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ptw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import ptw_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WALK  = 4'b0100,
        S_HOLD  = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [LVL_W-1:0]     lvl_reg, lvl_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [CNT_W-1:0]     nfs_reg, nfs_next;
    logic [CNT_W-1:0]     limit_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [1:0]           op_reg;
    logic [VA_W-1:0]      va_reg;
    logic [PAGE_W-1:0]    page_reg;
    logic                 ow_reg;
    logic [PA_W-1:0]      res_pa_reg, res_pa_next;
    status_t              res_st_reg, res_st_next;
    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [ENTRY_W-1:0]   mem [DEPTH];
    logic [ENTRY_W-1:0]   rdata_reg;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]   mem_wdata;

    logic                 accept, out_free, is_leaf, entry_ok, fin, load_out, cfg_we;
    logic [VA_W-1:0]      in_va, rd_va;
    logic [PAGE_W-1:0]    in_page;
    logic                 in_ow;
    logic [CNT_W-1:0]     limit_eff;
    logic [PA_W-1:0]      fin_pa, leaf_pa, rd_pa;
    status_t              fin_st;

    assign in_va   = s_tdata[VA_W-1:0];
    assign in_page = s_tdata[VA_W +: PAGE_W];
    assign in_ow   = s_tdata[VA_W + PAGE_W];

    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign is_leaf   = (lvl_reg == LVL_W'(LEVELS - 1));
    assign entry_ok  = rdata_reg[PAGE_W] && (rdata_reg[PAGE_W-1:0] < PAGE_W'(TABLE_SLOTS));
    assign limit_eff = (limit_reg > CNT_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS) : limit_reg;
    assign leaf_pa   = {page_reg, va_reg[OFF_W-1:0]};
    assign rd_pa     = {rdata_reg[PAGE_W-1:0], va_reg[OFF_W-1:0]};

    always_comb begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        lvl_next    = lvl_reg;
        slot_next   = slot_reg;
        nfs_next    = nfs_reg;
        res_pa_next = res_pa_reg;
        res_st_next = res_st_reg;
        fin         = 1'b0;
        fin_pa      = '0;
        fin_st      = ST_OK;
        mem_we      = 1'b0;
        mem_waddr   = addr_reg;
        mem_wdata   = '0;
        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    lvl_next  = '0;
                    slot_next = '0;
                    if (s_tuser != OP_TRANSLATE && s_tuser != OP_MAP && s_tuser != OP_UNMAP) begin
                        // An undefined operation leaves the tables alone.
                        res_pa_next = '0;
                        res_st_next = ST_OK;
                        state_next  = S_HOLD;
                    end else begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!is_leaf) begin
                    if (entry_ok) begin
                        slot_next = rdata_reg[SLOT_W-1:0];
                        lvl_next  = lvl_reg + 1'b1;
                    end else if (op_reg == OP_MAP) begin
                        if (nfs_reg >= limit_eff) begin
                            fin    = 1'b1;
                            fin_st = ST_EXHAUSTED;
                        end else begin
                            // Fresh slots were never handed out, so they are clear.
                            mem_we    = 1'b1;
                            mem_wdata = {1'b1, PAGE_W'(nfs_reg)};
                            slot_next = nfs_reg[SLOT_W-1:0];
                            nfs_next  = nfs_reg + 1'b1;
                            lvl_next  = lvl_reg + 1'b1;
                        end
                    end else begin
                        fin    = 1'b1;
                        fin_st = ST_ABSENT;
                    end
                end else begin
                    fin = 1'b1;
                    case (op_reg)
                        OP_TRANSLATE: begin
                            if (rdata_reg[PAGE_W]) begin
                                fin_pa = rd_pa;
                            end else begin
                                fin_st = ST_ABSENT;
                            end
                        end
                        OP_MAP: begin
                            if (!rdata_reg[PAGE_W] || ow_reg) begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b1, page_reg};
                                fin_pa    = leaf_pa;
                            end else if (rdata_reg[PAGE_W-1:0] == page_reg) begin
                                fin_pa = leaf_pa;
                            end else begin
                                fin_st = ST_MISMATCH;
                            end
                        end
                        default: begin
                            if (rdata_reg[PAGE_W]) begin
                                mem_we    = 1'b1;
                                mem_wdata = {1'b0, rdata_reg[PAGE_W-1:0]};
                            end
                        end
                    endcase
                end
                if (fin) begin
                    if (out_free) begin
                        state_next = S_IDLE;
                    end else begin
                        res_pa_next = fin_pa;
                        res_st_next = fin_st;
                        state_next  = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // The read for the next level is issued in the same cycle its slot is known.
    assign rd_va     = accept ? in_va : va_reg;
    assign mem_raddr = {slot_next, level_index(rd_va, lvl_next)};

    assign load_out = ((state_reg == S_WALK) && fin && out_free) ||
                      ((state_reg == S_HOLD) && out_free);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            lvl_reg     <= '0;
            slot_reg    <= '0;
            nfs_reg     <= CNT_W'(1);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            lvl_reg   <= lvl_next;
            slot_reg  <= slot_next;
            nfs_reg   <= nfs_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg   <= mem_raddr;
        res_pa_reg <= res_pa_next;
        res_st_reg <= res_st_next;
        if (accept) begin
            op_reg   <= s_tuser;
            va_reg   <= in_va;
            page_reg <= in_page;
            ow_reg   <= in_ow;
        end
        if (load_out) begin
            if (state_reg == S_HOLD) begin
                m_data_reg <= M_TDATA_W'({res_st_reg, res_pa_reg});
            end else begin
                m_data_reg <= M_TDATA_W'({fin_st, fin_pa});
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Configuration port.
    assign cfg_we = psel && penable && pwrite && pready &&
                    (paddr == APB_ADDR_W'(REG_SLOT_LIMIT_ADDR));
    assign pready = 1'b1;
    assign prdata = (paddr == APB_ADDR_W'(REG_SLOT_LIMIT_ADDR)) ?
                    APB_DATA_W'(limit_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= CNT_W'(SLOT_LIMIT_RESET);
        end else if (cfg_we) begin
            limit_reg <= pwdata[CNT_W-1:0];
        end
    end

endmodule

[hw/rtl/ptw_checker.sv]
// Port-level checks for the page table walker, bound to its top level.
// Depends on ptw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptw_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ptw_pkg::M_TDATA_W-1:0]    m_tdata
);
    import ptw_pkg::*;

    logic [1:0]      m_status;
    logic [PA_W-1:0] m_pa;

    assign m_status = m_tdata[PA_W +: 2];
    assign m_pa     = m_tdata[PA_W-1:0];

    // A stalled result word holds its value.
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // A failed operation never reports an address.
    `ASSERT_IMPL(a_err_no_pa, aclk, aresetn, m_tvalid && m_status != ST_OK, m_pa == '0)

    // Items are walked one at a time, so a taken word is never followed at once.
    `ASSERT_NEXT(a_one_walk, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // The table store is being cleared when reset is released.
    `ASSERT_IMPL(a_clear_first, aclk, aresetn, $rose(aresetn), !s_tready)

endmodule

bind page_table_walker_top ptw_checker u_ptw_checker (.*);

[dv/page_table_walker_top_test.sv]
// Self-checking test of the page table walker: a mirror of the table store
// predicts every result word while the stream and APB ports are exercised.
// Depends on ptw_pkg and page_table_walker_top.
`timescale 1ns / 1ps

module page_table_walker_top_test;
    import ptw_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int PREFIXES    = 5;

    typedef struct packed {
        logic [PA_W-1:0] pa;
        status_t         status;
    } walk_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // virtual_address[47:0], physical_page[87:48], overwrite[88], zero pad
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // opcode[1:0]
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // physical_address[51:0], status[53:52], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    page_table_walker_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // Mirror of the block's state.
    logic [ENTRY_W-1:0] table_mirror [0:DEPTH-1];
    logic [CNT_W-1:0]   free_slot_mirror;
    logic [CNT_W-1:0]   slot_limit_mirror;

    walk_result_t awaited_walks [$];
    walk_result_t head_walk;

    int  fail_count      = 0;
    int  words_sent      = 0;
    int  words_checked   = 0;
    int  limit_writes    = 0;
    int  status_seen [4] = '{0, 0, 0, 0};
    bit  idle_off        = 1'b0;
    bit  rx_hold_pending = 1'b0;
    bit  rx_holding      = 1'b0;

    // Address pool: prefixes are the three upper indices of a path, so that most
    // random words walk all the way down to a leaf table.
    logic [IDX_W-1:0]  pre0 [PREFIXES];
    logic [IDX_W-1:0]  pre1 [PREFIXES];
    logic [IDX_W-1:0]  pre2 [PREFIXES];
    logic [IDX_W-1:0]  leaf_pool [6];
    logic [PAGE_W-1:0] page_pool [4];
    logic [IDX_W-1:0]  absent_l0;

    function automatic logic [IDX_W-1:0] table_index(input logic [VA_W-1:0] va,
                                                     input int depth);
        int sh;
        sh = OFF_W + IDX_W * (LEVELS - 1 - depth);
        if (sh >= 64)
            return '0;
        return IDX_W'(64'(va) >> sh);
    endfunction

    function automatic logic [VA_W-1:0] make_va(input logic [IDX_W-1:0] i0,
                                                input logic [IDX_W-1:0] i1,
                                                input logic [IDX_W-1:0] i2,
                                                input logic [IDX_W-1:0] i3,
                                                input logic [OFF_W-1:0] off);
        return {i0, i1, i2, i3, off};
    endfunction

    // Walks the mirrored tables for one accepted word and applies its effect.
    function automatic walk_result_t walk_tables(input logic [1:0] op,
                                                 input logic [VA_W-1:0] va,
                                                 input logic [PAGE_W-1:0] page,
                                                 input logic ow);
        walk_result_t     res;
        logic [CNT_W-1:0] slot;
        logic [CNT_W-1:0] limit;
        logic [IDX_W-1:0] idx;
        logic [ENTRY_W-1:0] entry;
        int               addr;
        int               lvl;
        res.pa     = '0;
        res.status = ST_OK;
        slot       = '0;
        limit      = (slot_limit_mirror > TABLE_SLOTS) ? CNT_W'(TABLE_SLOTS)
                                                       : slot_limit_mirror;
        if (op == OP_TRANSLATE || op == OP_MAP || op == OP_UNMAP) begin
            for (lvl = 0; lvl < LEVELS - 1 && res.status == ST_OK; lvl++) begin
                idx   = table_index(va, lvl);
                addr  = int'(slot) * ENTRIES + int'(idx);
                entry = table_mirror[addr];
                // An intermediate entry pointing past the store is as good as absent.
                if (entry[PAGE_W] && entry[PAGE_W-1:0] < TABLE_SLOTS) begin
                    slot = CNT_W'(entry[PAGE_W-1:0]);
                end else if (op == OP_MAP) begin
                    if (free_slot_mirror >= limit) begin
                        res.status = ST_EXHAUSTED;
                    end else begin
                        table_mirror[addr] = {1'b1, PAGE_W'(free_slot_mirror)};
                        slot               = free_slot_mirror;
                        free_slot_mirror   = free_slot_mirror + 1'b1;
                    end
                end else begin
                    res.status = ST_ABSENT;
                end
            end
            if (res.status == ST_OK) begin
                addr  = int'(slot) * ENTRIES + int'(table_index(va, LEVELS - 1));
                entry = table_mirror[addr];
                case (op)
                    OP_TRANSLATE: begin
                        if (entry[PAGE_W])
                            res.pa = {entry[PAGE_W-1:0], va[OFF_W-1:0]};
                        else
                            res.status = ST_ABSENT;
                    end
                    OP_MAP: begin
                        if (!entry[PAGE_W] || ow)
                            table_mirror[addr] = {1'b1, page};
                        if (table_mirror[addr][PAGE_W-1:0] == page)
                            res.pa = {page, va[OFF_W-1:0]};
                        else
                            res.status = ST_MISMATCH;
                    end
                    default: begin
                        table_mirror[addr][PAGE_W] = 1'b0;
                    end
                endcase
            end
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (idle_off)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Offers one word and returns once it is taken; a zero gap leaves tvalid
    // high so that the next word follows back to back.
    task automatic send_word(input logic [1:0] op, input logic [VA_W-1:0] va,
                             input logic [PAGE_W-1:0] page, input logic ow);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= S_TDATA_W'({ow, page, va});
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        awaited_walks.push_back(walk_tables(op, va, page, ow));
        words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_results();
        int waited;
        waited   = 0;
        s_tvalid <= 1'b0;
        while (awaited_walks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (LEVELS + 2) @(posedge aclk);
    endtask

    // Writes the slot limit, then reads it straight back.
    task automatic program_slot_limit(input logic [CNT_W-1:0] value);
        logic [APB_DATA_W-1:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_SLOT_LIMIT_ADDR);
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        slot_limit_mirror = value;
        limit_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        readback = prdata;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback != APB_DATA_W'(slot_limit_mirror))
            note_failure($sformatf("slot limit read back %0d, expected %0d",
                                   readback, slot_limit_mirror));
    endtask

    // With only the root allowed, nothing can be mapped and every walk stops at
    // the root; the reserved opcode leaves everything alone.
    task automatic test_root_exhaustion();
        logic [VA_W-1:0] va_a;
        va_a = make_va(pre0[0], pre1[0], pre2[0], leaf_pool[0], OFF_W'($urandom));
        program_slot_limit(CNT_W'(1));
        send_word(OP_MAP, va_a, page_pool[0], 1'b0);
        send_word(OP_TRANSLATE, va_a, '0, 1'b0);
        send_word(OP_UNMAP, va_a, '0, 1'b0);
        send_word(OP_RESERVED, VA_W'({$urandom, $urandom}),
                  PAGE_W'({$urandom, $urandom}), 1'b1);
    endtask

    task automatic test_map_translate_unmap();
        logic [VA_W-1:0] va_a;
        logic [VA_W-1:0] va_sib;
        logic [VA_W-1:0] va_gone;
        va_a    = make_va(pre0[0], pre1[0], pre2[0], leaf_pool[0], OFF_W'($urandom));
        va_sib  = make_va(pre0[0], pre1[0], pre2[0], leaf_pool[1], OFF_W'($urandom));
        va_gone = make_va(absent_l0, pre1[0], pre2[0], leaf_pool[0], OFF_W'($urandom));
        wait_for_results();
        program_slot_limit(CNT_W'(1024));
        send_word(OP_MAP, va_a, page_pool[0], 1'b0);
        send_word(OP_TRANSLATE, va_a, '0, 1'b0);
        send_word(OP_MAP, va_a, page_pool[0], 1'b0);
        send_word(OP_MAP, va_a, page_pool[1], 1'b0);
        send_word(OP_MAP, va_a, page_pool[1], 1'b1);
        send_word(OP_TRANSLATE, va_a, page_pool[2], 1'b1);
        // Same leaf table, but the leaf entry itself was never written.
        send_word(OP_TRANSLATE, va_sib, '0, 1'b0);
        send_word(OP_UNMAP, va_sib, '0, 1'b0);
        send_word(OP_UNMAP, va_a, '0, 1'b0);
        send_word(OP_TRANSLATE, va_a, '0, 1'b0);
        send_word(OP_UNMAP, va_gone, '0, 1'b0);
        send_word(OP_MAP, '1, '1, 1'b1);
        send_word(OP_TRANSLATE, '1, '1, 1'b1);
        send_word(OP_MAP, '0, '0, 1'b0);
        send_word(OP_TRANSLATE, '0, '0, 1'b0);
    endtask

    // A map that runs out of slots half way keeps the tables it took; a later
    // map of the same path carries on from there.
    task automatic test_partial_allocation();
        logic [VA_W-1:0] va_p5;
        logic [VA_W-1:0] va_p4;
        va_p5 = make_va(pre0[4], pre1[4], pre2[4], leaf_pool[2], OFF_W'($urandom));
        va_p4 = make_va(pre0[3], pre1[3], pre2[3], leaf_pool[3], OFF_W'($urandom));
        wait_for_results();
        program_slot_limit(free_slot_mirror + 1'b1);
        send_word(OP_MAP, va_p5, page_pool[2], 1'b0);
        wait_for_results();
        program_slot_limit(CNT_W'(SLOT_LIMIT_RESET));
        send_word(OP_MAP, va_p5, page_pool[2], 1'b0);
        send_word(OP_TRANSLATE, va_p5, '0, 1'b0);
        send_word(OP_MAP, va_p4, page_pool[3], 1'b1);
    endtask

    task automatic test_random_traffic(input int count, input logic [CNT_W-1:0] limit);
        int                n;
        int                r;
        int                p;
        logic [1:0]        op;
        logic [VA_W-1:0]   va;
        logic [PAGE_W-1:0] page;
        logic [IDX_W-1:0]  leaf;
        logic              ow;
        wait_for_results();
        program_slot_limit(limit);
        for (n = 0; n < count; n++) begin
            page = $urandom_range(0, 1) ? page_pool[$urandom_range(0, 3)]
                                        : PAGE_W'({$urandom, $urandom});
            ow   = ($urandom_range(0, 2) == 0);
            r    = $urandom_range(0, 99);
            if (r < 10) begin
                // Noise: any opcode, any address, mostly off the known paths.
                op = 2'($urandom_range(0, 3));
                va = VA_W'({$urandom, $urandom});
            end else begin
                p    = $urandom_range(0, PREFIXES - 1);
                leaf = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom)
                                                   : leaf_pool[$urandom_range(0, 5)];
                va   = make_va(pre0[p], pre1[p], pre2[p], leaf, OFF_W'($urandom));
                r    = $urandom_range(0, 99);
                op   = (r < 40) ? OP_TRANSLATE : (r < 80) ? OP_MAP : OP_UNMAP;
            end
            send_word(op, va, page, ow);
        end
    endtask

    // The receiver stops for a long stretch while words keep coming, so the
    // block fills and holds s_tready low; then the sender waits for the drain.
    task automatic test_output_backpressure();
        int n;
        wait_for_results();
        rx_hold_pending = 1'b1;
        wait (rx_holding);
        @(posedge aclk);
        idle_off = 1'b1;
        for (n = 0; n < 30; n++)
            send_word((n % 3 == 0) ? OP_MAP : OP_TRANSLATE,
                      make_va(pre0[n % PREFIXES], pre1[n % PREFIXES], pre2[n % PREFIXES],
                              leaf_pool[n % 6], OFF_W'($urandom)),
                      page_pool[n % 4], 1'b0);
        idle_off = 1'b0;
        wait_for_results();
    endtask

    task automatic test_steady_stream();
        idle_off = 1'b1;
        test_random_traffic(150, CNT_W'(1024));
        idle_off = 1'b0;
    endtask

    // Receiver: random stalls, with the long hold-off on request.
    initial begin : receiver
        int stall;
        int held;
        forever begin
            @(posedge aclk);
            if (rx_hold_pending) begin
                rx_hold_pending = 1'b0;
                rx_holding      = 1'b1;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                rx_holding = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            status_seen[m_tdata[PA_W+1:PA_W]]++;
            if (awaited_walks.size() == 0) begin
                note_failure($sformatf("unexpected word pa=%h status=%0d",
                                       m_tdata[PA_W-1:0], m_tdata[PA_W+1:PA_W]));
            end else begin
                head_walk = awaited_walks.pop_front();
                if (m_tdata[PA_W-1:0] != head_walk.pa ||
                    m_tdata[PA_W+1:PA_W] != head_walk.status)
                    note_failure($sformatf(
                        "word %0d: expected pa=%h status=%0d, got pa=%h status=%0d",
                        words_checked, head_walk.pa, head_walk.status,
                        m_tdata[PA_W-1:0], m_tdata[PA_W+1:PA_W]));
                words_checked++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("page_table_walker_top_test: FAIL");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEPTH; i++)
            table_mirror[i] = '0;
        free_slot_mirror  = CNT_W'(1);
        slot_limit_mirror = CNT_W'(SLOT_LIMIT_RESET);

        // Paths: A, all ones, all zeros, a sibling of A that needs one new
        // table, and a branch under the all-ones root entry that needs two.
        pre0[0] = IDX_W'($urandom_range(3, ENTRIES - 2));
        pre1[0] = IDX_W'($urandom);
        pre2[0] = IDX_W'($urandom);
        pre0[1] = '1;
        pre1[1] = '1;
        pre2[1] = '1;
        pre0[2] = '0;
        pre1[2] = '0;
        pre2[2] = '0;
        pre0[3] = pre0[0];
        pre1[3] = pre1[0];
        pre2[3] = pre2[0] + IDX_W'($urandom_range(1, ENTRIES - 1));
        pre0[4] = '1;
        pre1[4] = IDX_W'($urandom_range(0, ENTRIES - 2));
        pre2[4] = IDX_W'($urandom);
        absent_l0 = IDX_W'($urandom_range(1, 2));
        for (int i = 0; i < 6; i++)
            leaf_pool[i] = IDX_W'($urandom);
        leaf_pool[1] = leaf_pool[0] ^ 9'h155;
        for (int i = 0; i < 4; i++)
            page_pool[i] = PAGE_W'({$urandom, $urandom});
        page_pool[1] = ~page_pool[0];

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_root_exhaustion();
        test_map_translate_unmap();
        test_partial_allocation();
        test_random_traffic(300, CNT_W'(1024));
        test_output_backpressure();
        test_random_traffic(250, CNT_W'($urandom_range(1, TABLE_SLOTS)));
        test_steady_stream();
        test_random_traffic(150, CNT_W'(1));
        test_random_traffic(150, CNT_W'(SLOT_LIMIT_RESET));

        wait_for_results();
        if (awaited_walks.size() != 0)
            note_failure($sformatf("%0d expected words never arrived",
                                   awaited_walks.size()));
        $display("Sent %0d words, checked %0d, over %0d slot limit writes with read-back.",
                 words_sent, words_checked, limit_writes);
        $display("Statuses seen: ok %0d, absent %0d, exhausted %0d, mismatch %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (fail_count == 0)
            $display("page_table_walker_top_test: PASS");
        else
            $display("page_table_walker_top_test: FAIL");
        $finish;
    end

endmodule
